### rtl/dense_shortest_path_engine_top_macros.svh
// assertion macros for the shortest path engine
`ifndef DENSE_SHORTEST_PATH_ENGINE_TOP_MACROS_SVH
`define DENSE_SHORTEST_PATH_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dsp_pkg.sv
// types and constants shared by the shortest path engine
`timescale 1ns / 1ps
package dsp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_PICK,
      ST_RELAX,
      ST_OUT
   } dsp_state_type;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_VERTEX = 2'd1;

   localparam logic [4:0]  VERTEX_COUNT_RESET = 5'd16;
   localparam logic [3:0]  SOURCE_RESET       = 4'd0;
   localparam logic [19:0] DIST_SAT           = 20'hFFFFF;

   typedef struct packed {
      logic [4:0] vertex_count;
      logic [3:0] source_vertex;
   } dsp_cfg_type;

endpackage

### rtl/dense_shortest_path_engine_top.sv
// top level of the dense shortest path engine
// load: one matrix item per cycle while idle; an item without last gives no result
// search: one set-up state, then n-1 rounds, each a pick scan over the vertices and, when the
// picked vertex is reachable, a relax pass over its row, all over the registered memory ports
// output: n-1 results, one per cycle, after the last round
// no stall; reset is synchronous and returns to idle
`timescale 1ns / 1ps
`include "dense_shortest_path_engine_top_macros.svh"
module dense_shortest_path_engine_top #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [3:0]                          req_row,
   input  logic [3:0]                          req_col,
   input  logic [15:0]                         req_weight,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic [3:0]                          rsp_vertex,
   output logic [19:0]                         rsp_distance,
   output logic                                rsp_reachable,
   output logic [3:0]                          rsp_parent,
   output logic                                rsp_final_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dsp_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dsp_pkg::*;

   // vertex index, count (holds n itself), matrix address, distance and vertex memory word widths
   localparam int VIDX = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW   = $clog2(MAX_VERTICES + 1);
   localparam int AW   = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int DW   = WEIGHT_BITS + VIDX;
   localparam int VMW  = DW + VIDX;

   dsp_cfg_type cfg;

   dsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // memories: weight matrix, and per vertex {distance, predecessor}
   logic [WEIGHT_BITS-1:0] wmem [MAX_VERTICES*MAX_VERTICES];
   logic [VMW-1:0]         vmem [MAX_VERTICES];

   logic                   wm_we;
   logic [AW-1:0]          wm_waddr, wm_raddr;
   logic [WEIGHT_BITS-1:0] wm_wdata, w_rd_ff;
   logic                   vm_we;
   logic [VIDX-1:0]        vm_waddr, vm_raddr;
   logic [VMW-1:0]         vm_wdata, v_rd_ff;

   // sequencer state
   dsp_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            p_ff, p_in;
   logic [VIDX-1:0] pidx_ff, pidx_in;
   logic [CW-1:0]   round_ff, round_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [VIDX-1:0] best_ff, best_in;
   logic [DW-1:0]   best_d_ff, best_d_in;
   logic            have_ff, have_in;
   logic            best_reach_ff, best_reach_in;
   logic [MAX_VERTICES-1:0] unreached_ff, unreached_in;
   logic [MAX_VERTICES-1:0] settled_ff, settled_in;

   logic            accept;
   logic            issue, scan_done, last_round;
   logic [CW-1:0]   n_sat;
   logic [47:0]     weight_wide;
   logic [DW-1:0]   rd_dist, cand;
   logic [VIDX-1:0] rd_pred;
   logic [DW+19:0]  dist_wide;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign issue       = (cnt_ff < n_ff);
   assign scan_done   = (cnt_ff == n_ff) && !p_ff;
   assign last_round  = (round_ff == n_ff - CW'(2));
   assign weight_wide = {32'd0, req_weight};
   assign rd_dist     = v_rd_ff[VMW-1:VIDX];
   assign rd_pred     = v_rd_ff[VIDX-1:0];
   assign cand        = best_d_ff + DW'(w_rd_ff);
   assign dist_wide   = (DW+20)'(rd_dist);

   // vertex count held between 2 and MAX_VERTICES, the most the memories cover
   always_comb begin
      if (cfg.vertex_count < 5'd2) begin
         n_sat = CW'(2);
      end else if (32'(cfg.vertex_count) > MAX_VERTICES) begin
         n_sat = CW'(MAX_VERTICES);
      end else begin
         n_sat = CW'(cfg.vertex_count);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) state_in = ST_INIT;
         end
         ST_INIT: state_in = ST_PICK;
         ST_PICK: begin
            if (scan_done) begin
               if (best_reach_ff)   state_in = ST_RELAX;
               else if (last_round) state_in = ST_OUT;
               else                 state_in = ST_PICK;
            end
         end
         ST_RELAX: begin
            if (scan_done) state_in = last_round ? ST_OUT : ST_PICK;
         end
         ST_OUT: begin
            if (scan_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in        = cnt_ff;
      p_in          = 1'b0;
      pidx_in       = pidx_ff;
      round_in      = round_ff;
      n_in          = n_ff;
      best_in       = best_ff;
      best_d_in     = best_d_ff;
      have_in       = have_ff;
      best_reach_in = best_reach_ff;
      unreached_in  = unreached_ff;
      settled_in    = settled_ff;
      wm_we    = 1'b0;
      wm_waddr = AW'(AW'(req_row) * AW'(MAX_VERTICES) + AW'(req_col));
      wm_wdata = weight_wide[WEIGHT_BITS-1:0];
      wm_raddr = AW'(AW'(best_ff) * AW'(MAX_VERTICES) + AW'(cnt_ff[VIDX-1:0]));
      vm_we    = 1'b0;
      vm_waddr = pidx_ff;
      vm_wdata = {cand, best_ff};
      vm_raddr = cnt_ff[VIDX-1:0];

      // scan counter shared by pick, relax and output passes
      if (state_ff == ST_PICK || state_ff == ST_RELAX || state_ff == ST_OUT) begin
         if (issue) begin
            p_in    = 1'b1;
            pidx_in = cnt_ff[VIDX-1:0];
            cnt_in  = cnt_ff + CW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // entries outside the matrix are dropped
            wm_we = accept && (32'(req_row) < MAX_VERTICES) && (32'(req_col) < MAX_VERTICES);
            if (accept && req_last) n_in = n_sat;
         end
         ST_INIT: begin
            unreached_in = '1;
            settled_in   = '0;
            cnt_in       = '0;
            round_in     = '0;
            have_in      = 1'b0;
            if (32'(cfg.source_vertex) < 32'(n_ff)) begin
               unreached_in[VIDX'(cfg.source_vertex)] = 1'b0;
               vm_we    = 1'b1;
               vm_waddr = VIDX'(cfg.source_vertex);
               vm_wdata = {DW'(0), VIDX'(cfg.source_vertex)};
            end
         end
         ST_PICK: begin
            // least distance, highest index on ties, unreachable loses
            if (p_ff && !settled_ff[pidx_ff]) begin
               if (!have_ff || !best_reach_ff ||
                   (!unreached_ff[pidx_ff] && rd_dist <= best_d_ff)) begin
                  best_in       = pidx_ff;
                  best_d_in     = rd_dist;
                  best_reach_in = !unreached_ff[pidx_ff];
                  have_in       = 1'b1;
               end
            end
            if (scan_done) begin
               settled_in[best_ff] = 1'b1;
               have_in = 1'b0;
               cnt_in  = '0;
               if (!best_reach_ff) begin
                  if (last_round) cnt_in = CW'(1);
                  else            round_in = round_ff + CW'(1);
               end
            end
         end
         ST_RELAX: begin
            if (p_ff && !settled_ff[pidx_ff] && (w_rd_ff != '0) &&
                (unreached_ff[pidx_ff] || cand < rd_dist)) begin
               vm_we = 1'b1;
               unreached_in[pidx_ff] = 1'b0;
            end
            if (scan_done) begin
               if (last_round) begin
                  cnt_in = CW'(1);
               end else begin
                  cnt_in   = '0;
                  round_in = round_ff + CW'(1);
               end
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   // result ports, straight from the registered read
   always_comb begin
      rsp_valid     = (state_ff == ST_OUT) && p_ff;
      rsp_vertex    = 4'(pidx_ff);
      rsp_reachable = !unreached_ff[pidx_ff];
      rsp_final_res = ((CW'(pidx_ff) + CW'(1)) == n_ff);
      rsp_distance  = '0;
      rsp_parent    = '0;
      if (rsp_reachable) begin
         rsp_distance = (dist_wide > (DW+20)'(DIST_SAT)) ? DIST_SAT : dist_wide[19:0];
         rsp_parent   = 4'(rd_pred);
      end
   end

   always_ff @(posedge clock) begin
      if (wm_we) wmem[wm_waddr] <= wm_wdata;
      w_rd_ff <= wmem[wm_raddr];
   end

   always_ff @(posedge clock) begin
      if (vm_we) vmem[vm_waddr] <= vm_wdata;
      v_rd_ff <= vmem[vm_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         p_ff          <= 1'b0;
         round_ff      <= '0;
         n_ff          <= CW'(2);
         have_ff       <= 1'b0;
         best_reach_ff <= 1'b0;
         unreached_ff  <= '1;
         settled_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         p_ff          <= p_in;
         round_ff      <= round_in;
         n_ff          <= n_in;
         have_ff       <= have_in;
         best_reach_ff <= best_reach_in;
         unreached_ff  <= unreached_in;
         settled_ff    <= settled_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff   <= pidx_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
   end

   // results only come out of a running search, never for vertex zero
   `DSP_ASSERT_NOW(a_rsp_busy, clock, reset, rsp_valid, busy && (rsp_vertex != 4'd0), "result while idle or for vertex zero")
   // a last item starts the search
   `DSP_ASSERT_NEXT(a_start, clock, reset, accept && req_last, state_ff == ST_INIT, "search did not start")
   // the final result closes the run
   `DSP_ASSERT_NEXT(a_final, clock, reset, rsp_valid && rsp_final_res, !rsp_valid, "result after final")
   // a relax pass only follows a reachable pick
   `DSP_ASSERT_NEXT(a_relax, clock, reset, (state_ff == ST_PICK) && scan_done && !best_reach_ff, state_ff != ST_RELAX, "relax from unreachable vertex")

endmodule

### rtl/dsp_csr.sv
// configuration registers of the shortest path engine
`timescale 1ns / 1ps
module dsp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dsp_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output dsp_pkg::dsp_cfg_type               cfg
);
   import dsp_pkg::*;

   logic [4:0] vc_ff, vc_in;
   logic [3:0] src_ff, src_in;

   assign csr_ready = 1'b1;

   always_comb begin
      vc_in  = vc_ff;
      src_in = src_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  vc_in  = csr_data[4:0];
            CSR_SOURCE_VERTEX: src_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff  <= VERTEX_COUNT_RESET;
         src_ff <= SOURCE_RESET;
      end else begin
         vc_ff  <= vc_in;
         src_ff <= src_in;
      end
   end

   assign cfg.vertex_count  = vc_ff;
   assign cfg.source_vertex = src_ff;

endmodule
